[rtl/atmt_pkg.sv]
package atmt_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int REF_WIDTH_DEF = 16;
   localparam int ID_W = 16;
   localparam int CNT_W = 5;

   localparam logic [2:0] OP_QUERY = 3'd0;
   localparam logic [2:0] OP_PUSH_OUT = 3'd1;
   localparam logic [2:0] OP_PUSH_IN = 3'd2;
   localparam logic [2:0] OP_MARK = 3'd3;
   localparam logic [2:0] OP_FLUSH = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic [15:0] msg_id;
      logic [15:0] body_ref;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic [15:0] assigned_id;
      logic pending_found;
      logic [15:0] pending_id;
      logic [15:0] pending_body_ref;
      logic [4:0] pending_count;
      logic [4:0] entry_count;
      logic [15:0] next_seq_id;
   } rsp_type;

endpackage

[rtl/ack_tracked_message_table_unit.sv]
// A query, a push or an undefined op scans the held entries once for the status; a mark
// walks the table up to the matching entry and a flush walks all of it before that scan,
// each read going through the single read port of the entry memory. One item is in work at
// a time; the next item is accepted the cycle after the result is loaded, and loading waits
// while the previous result is held. Reset clears the count, sets the sequence id to one;
// entry storage is not cleared.
module ack_tracked_message_table_unit
   import atmt_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int REF_WIDTH = REF_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int DW = ID_W + 2 + REF_WIDTH;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MARK = 3'd1;
   localparam logic [2:0] S_FLUSH = 3'd2;
   localparam logic [2:0] S_STAT = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // Entry word: {id, outbound, acked, ref}.
   logic we;
   logic [AW-1:0] waddr, raddr;
   logic [DW-1:0] wdata, rdata;

   atmt_mem #(.ENTRIES(ENTRIES), .DW(DW)) u_mem (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] held_ff, held_in;
   logic [15:0] seq_ff, seq_in;
   logic [CW:0] idx_ff, idx_in;       // read index being issued
   logic rd_vld_ff, rd_vld_in;        // rdata belongs to idx_ff-1
   logic [CW-1:0] kept_ff, kept_in;
   logic [CW-1:0] pos_ff, pos_in;     // entry index of rdata
   req_type req_ff, req_in;
   rsp_type res_ff, res_in;
   logic out_vld_ff, out_vld_in;
   rsp_type out_ff, out_in;

   logic [15:0] r_id;
   logic r_out, r_ack;
   logic [REF_WIDTH-1:0] r_ref;
   assign {r_id, r_out, r_ack, r_ref} = rdata;

   logic [CW:0] held_ext;
   assign held_ext = {1'b0, held_ff};
   assign raddr = idx_ff[AW-1:0];
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_vld_ff;
   assign rsp_data = out_ff;

   always_comb begin
      state_in = state_ff;
      held_in = held_ff;
      seq_in = seq_ff;
      idx_in = idx_ff;
      rd_vld_in = 1'b0;
      kept_in = kept_ff;
      pos_in = pos_ff;
      req_in = req_ff;
      res_in = res_ff;
      out_vld_in = out_vld_ff;
      out_in = out_ff;
      we = 1'b0;
      waddr = held_ff[AW-1:0];
      wdata = '0;
      if (out_vld_ff && rsp_ready) begin
         out_vld_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
               idx_in = '0;
               kept_in = '0;
               state_in = S_STAT;
               case (req_data.op)
                  OP_QUERY: res_in.accepted = 1'b1;
                  OP_PUSH_OUT, OP_PUSH_IN: begin
                     if (held_ext < (CW+1)'(ENTRIES)) begin
                        we = 1'b1;
                        res_in.accepted = 1'b1;
                        if (req_data.op == OP_PUSH_OUT) begin
                           wdata = {seq_ff, 1'b1, 1'b0, req_data.body_ref[REF_WIDTH-1:0]};
                           res_in.assigned_id = seq_ff;
                           seq_in = seq_ff + 16'd1;
                        end else begin
                           wdata = {req_data.msg_id, 1'b0, 1'b1,
                                    req_data.body_ref[REF_WIDTH-1:0]};
                           res_in.assigned_id = req_data.msg_id;
                        end
                        held_in = held_ff + CW'(1);
                     end
                  end
                  OP_MARK: state_in = S_MARK;
                  OP_FLUSH: begin
                     res_in.accepted = 1'b1;
                     state_in = S_FLUSH;
                  end
                  default: ;
               endcase
            end
         end
         S_MARK, S_FLUSH, S_STAT: begin
            // Issue reads up to held; consume rdata in the cycle after each read.
            if (idx_ff < held_ext) begin
               idx_in = idx_ff + (CW+1)'(1);
               rd_vld_in = 1'b1;
               pos_in = idx_ff[CW-1:0];
            end
            if (rd_vld_ff) begin
               if (state_ff == S_MARK) begin
                  if (r_id == req_ff.msg_id) begin
                     we = 1'b1;
                     waddr = pos_ff[AW-1:0];
                     wdata = {r_id, r_out, 1'b1, r_ref};
                     res_in.accepted = 1'b1;
                     idx_in = '0;
                     rd_vld_in = 1'b0;
                     state_in = S_STAT;
                  end
               end else if (state_ff == S_FLUSH) begin
                  if (!r_ack) begin
                     we = 1'b1;
                     waddr = kept_ff[AW-1:0];
                     wdata = {r_id, r_out, 1'b0, r_ref};
                     kept_in = kept_ff + CW'(1);
                  end
               end else if (r_out && !r_ack) begin
                  if (!res_in.pending_found) begin
                     res_in.pending_found = 1'b1;
                     res_in.pending_id = r_id;
                     res_in.pending_body_ref = 16'(r_ref);
                  end
                  res_in.pending_count = res_in.pending_count + 5'd1;
               end
            end
            if (idx_ff >= held_ext && !rd_vld_ff && state_in == state_ff) begin
               idx_in = '0;
               if (state_ff == S_FLUSH) begin
                  held_in = kept_ff;
                  state_in = S_STAT;
               end else if (state_ff == S_MARK) begin
                  state_in = S_STAT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!out_vld_ff || rsp_ready) begin
               out_vld_in = 1'b1;
               out_in = res_ff;
               out_in.entry_count = 5'(held_ff);
               out_in.next_seq_id = seq_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff <= '0;
         seq_ff <= 16'd1;
         rd_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         seq_ff <= seq_in;
         rd_vld_ff <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
      idx_ff <= idx_in;
      kept_ff <= kept_in;
      pos_ff <= pos_in;
      req_ff <= req_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(ENTRIES)) else $error("held count beyond depth");
   a_pend_le_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pending_count <= rsp_data.entry_count)
      else $error("pending count above entry count");
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pending_found == (rsp_data.pending_count != 5'd0)))
      else $error("pending flag disagrees with count");

endmodule

[rtl/atmt_mem.sv]
module atmt_mem
   import atmt_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int DW = 34,
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic clock,
   input  logic we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[test/tb_ack_tracked_message_table_unit.sv]
`timescale 1ns / 1ps

module tb_ack_tracked_message_table_unit;
   import atmt_pkg::*;

   localparam int DEPTH = ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 900000;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Mirror of the message table; predicts the status reported after each operation.
   class table_scoreboard;
      logic [15:0] ids[DEPTH];
      logic        outbound[DEPTH];
      logic        acked[DEPTH];
      logic [15:0] refs[DEPTH];
      int          held;
      logic [15:0] seq_id;
      rsp_type     status_queue[$];

      function void clear();
         held = 0;
         seq_id = 16'd1;
         status_queue.delete();
      endfunction

      function void note_request(req_type req);
         rsp_type r;
         int kept;
         int i;
         bit hit;
         r = '0;
         case (req.op)
            OP_QUERY: r.accepted = 1'b1;
            OP_PUSH_OUT: if (held < DEPTH) begin
               ids[held] = seq_id; outbound[held] = 1'b1; acked[held] = 1'b0;
               refs[held] = req.body_ref; held++;
               r.accepted = 1'b1; r.assigned_id = seq_id; seq_id = seq_id + 16'd1;
            end
            OP_PUSH_IN: if (held < DEPTH) begin
               ids[held] = req.msg_id; outbound[held] = 1'b0; acked[held] = 1'b1;
               refs[held] = req.body_ref; held++;
               r.accepted = 1'b1; r.assigned_id = req.msg_id;
            end
            OP_MARK: begin
               hit = 0;
               for (i = 0; i < held; i++)
                  if (!hit && ids[i] == req.msg_id) begin
                     acked[i] = 1'b1; hit = 1;
                  end
               r.accepted = hit;
            end
            OP_FLUSH: begin
               kept = 0;
               for (i = 0; i < held; i++)
                  if (!acked[i]) begin
                     ids[kept] = ids[i]; outbound[kept] = outbound[i];
                     acked[kept] = 1'b0; refs[kept] = refs[i]; kept++;
                  end
               held = kept;
               r.accepted = 1'b1;
            end
            default: ;
         endcase
         for (i = 0; i < held; i++)
            if (outbound[i] && !acked[i]) begin
               if (!r.pending_found) begin
                  r.pending_found = 1'b1; r.pending_id = ids[i];
                  r.pending_body_ref = refs[i];
               end
               r.pending_count++;
            end
         r.entry_count = held[4:0];
         r.next_seq_id = seq_id;
         status_queue.push_back(r);
      endfunction

      task check_status(rsp_type got);
         rsp_type w;
         if (status_queue.size() == 0) begin
            report_mismatch("unexpected result", 32'(got), 0);
            return;
         end
         w = status_queue.pop_front();
         if (got.accepted !== w.accepted) report_mismatch("accepted", got.accepted, w.accepted);
         if (got.assigned_id !== w.assigned_id)
            report_mismatch("assigned_id", got.assigned_id, w.assigned_id);
         if (got.pending_found !== w.pending_found)
            report_mismatch("pending_found", got.pending_found, w.pending_found);
         if (got.pending_id !== w.pending_id)
            report_mismatch("pending_id", got.pending_id, w.pending_id);
         if (got.pending_body_ref !== w.pending_body_ref)
            report_mismatch("pending_body_ref", got.pending_body_ref, w.pending_body_ref);
         if (got.pending_count !== w.pending_count)
            report_mismatch("pending_count", got.pending_count, w.pending_count);
         if (got.entry_count !== w.entry_count)
            report_mismatch("entry_count", got.entry_count, w.entry_count);
         if (got.next_seq_id !== w.next_seq_id)
            report_mismatch("next_seq_id", got.next_seq_id, w.next_seq_id);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;

   table_scoreboard table_model;
   longint cycle_count = 0;

   always #10 clock = ~clock;

   ack_tracked_message_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) table_model.check_status(rsp_data);
   end

   // Receiver: random stall before each transfer, with none for roughly a quarter of them.
   initial begin : receiver
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Valid stays high between back-to-back transfers and drops only ahead of a gap.
   task automatic send_request(input logic [2:0] op, input logic [15:0] id,
                               input logic [15:0] body, input int gap);
      req_type r;
      r.op = op; r.msg_id = id; r.body_ref = body;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      table_model.note_request(r);
      @(negedge clock);
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int draw_gap(bit busy_phase);
      return busy_phase ? 0 : $urandom_range(0, 14);
   endfunction

   // Picks an id that is likely to be held so marks mostly find their target.
   function automatic logic [15:0] pick_known_id();
      if (table_model.held > 0 && $urandom_range(0, 4) != 0)
         return table_model.ids[$urandom_range(0, table_model.held - 1)];
      return 16'($urandom());
   endfunction

   initial begin : sender
      int n;
      int k;
      bit busy;
      logic [2:0] op;
      table_model = new();
      table_model.clear();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-table cases, fill to full, refused pushes, duplicates, flush.
      send_request(OP_QUERY, 16'h0000, 16'h0000, 0);
      send_request(OP_MARK, 16'h0001, 16'h0000, 1);
      send_request(OP_FLUSH, 16'h0000, 16'h0000, 0);
      send_request(3'd5, 16'hFFFF, 16'hFFFF, 2);
      send_request(3'd7, 16'h0000, 16'h0000, 0);
      send_request(OP_PUSH_OUT, 16'hFFFF, 16'hFFFF, 0);
      send_request(OP_PUSH_IN, 16'h0002, 16'h0000, 0);
      send_request(OP_PUSH_IN, 16'h0002, 16'h5555, 0);
      send_request(OP_PUSH_OUT, 16'h0000, 16'hAAAA, 3);
      send_request(OP_MARK, 16'h0002, 16'h0000, 0);
      for (k = 0; k < 12; k++) send_request(OP_PUSH_OUT, 16'h0, 16'($urandom()), 0);
      send_request(OP_PUSH_OUT, 16'h0, 16'h1234, 0);
      send_request(OP_PUSH_IN, 16'hFFFF, 16'h1234, 0);
      send_request(OP_MARK, 16'hBEEF, 16'h0, 0);
      send_request(OP_FLUSH, 16'h0, 16'h0, 0);

      // Random: mostly well-formed push/ack/flush traffic.
      for (n = 0; n < 1030; n++) begin
         busy = ($urandom_range(0, 9) < 3);
         k = $urandom_range(0, 99);
         if (k < 30) op = OP_PUSH_OUT;
         else if (k < 42) op = OP_PUSH_IN;
         else if (k < 72) op = OP_MARK;
         else if (k < 85) op = OP_FLUSH;
         else if (k < 93) op = OP_QUERY;
         else op = 3'($urandom_range(5, 7));
         send_request(op, (op == OP_MARK) ? pick_known_id() : 16'($urandom()),
                      16'($urandom()), draw_gap(busy));
         if (n == 400) begin
            // Hold off until every result has drained.
            release_request();
            while (table_model.status_queue.size() != 0) @(negedge clock);
         end
      end

      release_request();
      while (table_model.status_queue.size() != 0) @(negedge clock);
      repeat (2 * DEPTH + 20) @(negedge clock);
      if (error_count == 0 && table_model.status_queue.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
